### src/tpp_pkg.sv
`default_nettype none

package tpp_pkg;

  // Field and storage widths.
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LINES_W    = 10;
  localparam int unsigned SPEED_W    = 5;
  localparam int unsigned DELAY_BITS = 20;
  localparam int unsigned MAX_PADS   = 63;
  localparam int unsigned PAD_CNT_W  = 6;
  localparam int unsigned CT_W       = 11;
  // Remainder of the pad loop: delay plus half a character time.
  localparam int unsigned REM_W      = DELAY_BITS + 1;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR   = 1'b1;

  // Kind code carried with each result item.
  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  // Command from the parser to the output side.
  typedef struct packed {
    logic                  is_end;
    logic [CHAR_W-1:0]     ch;
    logic [DELAY_BITS-1:0] delay;
  } cmd_t;

  // Configuration register contents.
  typedef struct packed {
    logic [SPEED_W-1:0] line_speed;
    logic [CHAR_W-1:0]  pad_char;
  } cfg_t;

  // Time per character in tenths of a millisecond for each line speed code.
  function automatic logic [CT_W-1:0] char_time(input logic [SPEED_W-1:0] code);
    logic [CT_W-1:0] t;
    case (code)
      5'd1:    t = 11'd2000;
      5'd2:    t = 11'd1333;
      5'd3:    t = 11'd909;
      5'd4:    t = 11'd743;
      5'd5:    t = 11'd667;
      5'd6:    t = 11'd500;
      5'd7:    t = 11'd333;
      5'd8:    t = 11'd167;
      5'd9:    t = 11'd83;
      5'd10:   t = 11'd56;
      5'd11:   t = 11'd42;
      5'd12:   t = 11'd21;
      5'd13:   t = 11'd10;
      5'd14:   t = 11'd5;
      5'd15:   t = 11'd3;
      5'd16:   t = 11'd2;
      5'd17:   t = 11'd1;
      5'd18:   t = 11'd1;
      5'd19:   t = 11'd1;
      default: t = 11'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

### src/tpp_front.sv
`default_nettype none

module tpp_front (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [tpp_pkg::CHAR_W-1:0]    in_char_i,
  input  wire  [tpp_pkg::LINES_W-1:0]   lines_i,
  input  wire                           full_i,
  output logic                          push_o,
  output tpp_pkg::cmd_t                 cmd_o
);
  import tpp_pkg::*;

  typedef enum logic [1:0] {
    PH_INT      = 2'd0,
    PH_FRAC1    = 2'd1,
    PH_FRACSKIP = 2'd2,
    PH_TEXT     = 2'd3
  } phase_e;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [DELAY_BITS-1:0] DELAY_MAX = {DELAY_BITS{1'b1}};

  phase_e                   phase_q, phase_d;
  logic [DELAY_BITS-1:0]    delay_q, delay_d;
  logic                     accept;
  logic                     is_digit;
  logic [3:0]               digit;
  logic [DELAY_BITS+3:0]    int_sum;
  logic [DELAY_BITS:0]      frac_sum;
  logic [DELAY_BITS+LINES_W-1:0] star_prod;
  logic [DELAY_BITS-1:0]    int_sat, frac_sat, star_sat;

  // The parser only stalls when the queue is full.
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Candidate delay values for each kind of prefix byte, saturated.
  assign is_digit  = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
  assign digit     = 4'(in_char_i - CH_ZERO);
  assign int_sum   = ({4'd0, delay_q} + {{DELAY_BITS{1'b0}}, digit}) * (DELAY_BITS + 4)'(10);
  assign frac_sum  = {1'b0, delay_q} + {{(DELAY_BITS - 3){1'b0}}, digit};
  assign star_prod = {{LINES_W{1'b0}}, delay_q} * {{DELAY_BITS{1'b0}}, lines_i};
  assign int_sat   = (int_sum[DELAY_BITS+3:DELAY_BITS] != 4'd0) ? DELAY_MAX
                                                                  : int_sum[DELAY_BITS-1:0];
  assign frac_sat  = frac_sum[DELAY_BITS] ? DELAY_MAX : frac_sum[DELAY_BITS-1:0];
  assign star_sat  = (star_prod[DELAY_BITS+LINES_W-1:DELAY_BITS] != '0) ? DELAY_MAX
                                                                        : star_prod[DELAY_BITS-1:0];

  // Classify the item: prefix bytes are consumed and may update the delay, others go to the queue.
  always_comb begin
    phase_d      = phase_q;
    delay_d      = delay_q;
    push_o       = 1'b0;
    cmd_o.is_end = 1'b0;
    cmd_o.ch     = in_char_i;
    cmd_o.delay  = delay_q;
    if (accept) begin
      if (in_char_i == CH_NUL) begin
        push_o       = 1'b1;
        cmd_o.is_end = 1'b1;
        phase_d      = PH_INT;
        delay_d      = '0;
      end else if (phase_q != PH_TEXT) begin
        if (is_digit) begin
          case (phase_q)
            PH_INT: begin
              delay_d = int_sat;
            end
            PH_FRAC1: begin
              delay_d = frac_sat;
              phase_d = PH_FRACSKIP;
            end
            default: begin
            end
          endcase
        end else if (phase_q == PH_INT && in_char_i == CH_POINT) begin
          phase_d = PH_FRAC1;
        end else begin
          phase_d = PH_TEXT;
          if (in_char_i == CH_STAR) begin
            delay_d = star_sat;
          end else begin
            push_o = 1'b1;
          end
        end
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INT;
      delay_q <= '0;
    end else begin
      phase_q <= phase_d;
      delay_q <= delay_d;
    end
  end

endmodule

`default_nettype wire

### src/tpp_fifo.sv
`default_nettype none

module tpp_fifo (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  tpp_pkg::cmd_t  cmd_i,
  output logic           full_o,
  input  wire            pop_i,
  output tpp_pkg::cmd_t  cmd_o,
  output logic           empty_o
);
  import tpp_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == DEPTH);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH)
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

### src/tpp_back.sv
`default_nettype none

module tpp_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tpp_pkg::cfg_t                cfg_i,
  input  tpp_pkg::cmd_t                cmd_i,
  input  wire                          empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [tpp_pkg::CHAR_W-1:0]   out_char_o,
  output tpp_pkg::kind_e               out_kind_o,
  output logic                         out_last_o
);
  import tpp_pkg::*;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_PAD  = 1'b1
  } state_e;

  state_e                 state_q, state_d;
  logic [REM_W-1:0]       rem_q, rem_d;
  logic [CT_W-1:0]        ct_q, ct_d;
  logic [PAD_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  kind_e                  out_kind_q, out_kind_d;
  logic                   out_last_q, out_last_d;

  logic                   out_free;
  logic [CT_W-1:0]        ct_lookup;
  logic [REM_W-1:0]       num;
  logic [REM_W-1:0]       ct_ext;
  logic                   pad_last;

  assign out_free  = !out_valid_q || out_ready_i;
  assign ct_lookup = char_time(cfg_i.line_speed);
  // Adding half a character time rounds the quotient to nearest.
  assign num       = {1'b0, cmd_i.delay} + REM_W'(ct_lookup >> 1);
  assign ct_ext    = REM_W'(ct_q);
  // This pad is the last when less than two character times remain,
  // or when the pad count reaches its ceiling.
  assign pad_last  = (rem_q < REM_W'({ct_q, 1'b0})) || (cnt_q == PAD_CNT_W'(MAX_PADS - 1));

  // Command execution: text passes, an end command either emits one end marker or divides by
  // repeated subtraction and emits one pad per subtraction.
  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    ct_d        = ct_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          if (!cmd_i.is_end) begin
            out_valid_d = 1'b1;
            out_char_d  = cmd_i.ch;
            out_kind_d  = KIND_TEXT;
            out_last_d  = 1'b1;
          end else if (ct_lookup == '0 || num < REM_W'(ct_lookup)) begin
            out_valid_d = 1'b1;
            out_char_d  = '0;
            out_kind_d  = KIND_END;
            out_last_d  = 1'b1;
          end else begin
            state_d = S_PAD;
            rem_d   = num;
            ct_d    = ct_lookup;
            cnt_d   = '0;
          end
        end
      end
      S_PAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = cfg_i.pad_char;
          out_kind_d  = KIND_PAD;
          out_last_d  = pad_last;
          rem_d       = rem_q - ct_ext;
          cnt_d       = cnt_q + 1'b1;
          if (pad_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rem_q       <= '0;
      ct_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_kind_q  <= KIND_TEXT;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      ct_q        <= ct_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_char_q  <= out_char_d;
      out_kind_q  <= out_kind_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  a_pad_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD |-> (ct_q != '0) && (rem_q >= ct_ext))
    else $error("pad loop entered without a full character time left");

  a_pad_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD |-> cnt_q < PAD_CNT_W'(MAX_PADS))
    else $error("pad count beyond its ceiling");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == KIND_END || out_kind_q == KIND_TEXT) |-> out_last_q)
    else $error("single-result item without last flag");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PAD |-> !pop_o)
    else $error("command taken while pads are still going out");

endmodule

`default_nettype wire

### src/terminal_padding_parser_core.sv
`default_nettype none

// Terminal padding parser. Each input item carries one byte of a terminal
// control string plus a lines-affected count; a zero byte ends the string.
// A leading delay prefix (milliseconds, optional point and tenths digit,
// optional star that multiplies by the lines-affected count) is consumed and
// gives no result; every later byte comes out as one text item. At the zero
// byte the block emits round(delay / character time) pad items (at most 63),
// the character time coming from the line speed register, or a single end
// marker item when there is no padding. The parser handles prefix and text
// bytes as they arrive and stalls only when the queue is full; the output
// side sends text items and end markers from the queue, and for a padded end
// first loads a subtract loop that emits one pad per subtraction, holding
// while the output is not ready. A two-entry queue between parser and output
// side lets the parser keep accepting while pads are still going out.
// Configuration is written on the cfg channel, which is always ready; index 0
// is the line speed code, index 1 the pad byte.
module terminal_padding_parser_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Input stream: tdata [7:0] in_char, [17:8] lines_affected, [23:18] zero.
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire  [tpp_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // Output stream: tdata [7:0] out_char; tuser [1:0] kind; tlast last.
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  output logic [tpp_pkg::CHAR_W-1:0]      m_axis_tdata_o,
  output logic [1:0]                      m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  // Configuration write channel.
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [tpp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [tpp_pkg::CHAR_W-1:0]      cfg_data_i
);
  import tpp_pkg::*;

  cfg_t  cfg_q;
  cmd_t  push_cmd, head_cmd;
  logic  push, pop, full, empty;
  kind_e out_kind;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LINE_SPEED: cfg_q.line_speed <= cfg_data_i[SPEED_W-1:0];
        CFG_PAD_CHAR:   cfg_q.pad_char   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_char_i  (s_axis_tdata_i[CHAR_W-1:0]),
    .lines_i    (s_axis_tdata_i[CHAR_W+LINES_W-1:CHAR_W]),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tpp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty)
  );

  tpp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_kind_o  (out_kind),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_kind;

endmodule

`default_nettype wire
